FILE: sv/pcse_pkg.sv
// shared types, field widths and codes for the page content store engine
// no dependencies; imported by every module of the block
package pcse_pkg;

  localparam int PAGE_BYTES_DEF = 1024;

  localparam int CMD_W  = 3;
  localparam int OFF_W  = 10;
  localparam int LEN_W  = 11;
  localparam int BYTE_W = 8;
  localparam int ST_W   = 2;
  localparam int IDX_W  = 10;
  localparam int CNT_W  = 11;

  localparam logic [CNT_W-1:0] CNT_MAX = 11'd2047;

  // command codes
  localparam logic [CMD_W-1:0] OP_WRITE  = 3'd0;
  localparam logic [CMD_W-1:0] OP_APPEND = 3'd1;
  localparam logic [CMD_W-1:0] OP_CLEAR  = 3'd2;
  localparam logic [CMD_W-1:0] OP_FIND   = 3'd3;
  localparam logic [CMD_W-1:0] OP_COUNT  = 3'd4;
  localparam logic [CMD_W-1:0] OP_FIT    = 3'd5;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_NO_END    = 2'd2;

  // configuration register indexes
  localparam logic REG_END_MARKER   = 1'b0;
  localparam logic REG_EMPTY_MARKER = 1'b1;

  // which scan the datapath sets up
  typedef enum logic [2:0] {
    SS_FIND  = 3'd0,  // match data byte from offset
    SS_COUNT = 3'd1,  // count empty bytes
    SS_END   = 3'd2,  // match end marker from zero
    SS_FIRST = 3'd3,  // match empty marker from zero
    SS_FIT   = 3'd4   // empty run search from max(offset, first empty)
  } start_t;

  typedef struct packed {
    logic   item_load;
    logic   wr_item;
    logic   clr_start;
    logic   scan_start;
    start_t start_kind;
    logic   run;
    logic   app_begin;
    logic   app_put;
    logic   app_mark;
    logic   res_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] item_cmd;
    logic             item_whole;
    logic             app_active;
    logic             scan_done;
    logic             scan_hit;
  } ctl_stat_t;

endpackage

FILE: sv/pcse_ctrl.sv
// sequencing state machine of the page content store engine
// depends on pcse_pkg; drives the datapath through ctl_cmd_t
module pcse_ctrl
  import pcse_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  ctl_stat_t st,
  output ctl_cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DISPATCH = 9'b000000010,
    S_SCAN     = 9'b000000100,
    S_CLR      = 9'b000001000,
    S_APP_SCAN = 9'b000010000,
    S_APP_PUT  = 9'b000100000,
    S_APP_END  = 9'b001000000,
    S_FIT1     = 9'b010000000,
    S_DONE     = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.start_kind = SS_FIND;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.item_load = 1'b1;
          state_next    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (st.item_cmd)
          OP_WRITE: begin
            cmd.wr_item = 1'b1;
            state_next  = S_DONE;
          end
          OP_APPEND: begin
            if (st.app_active) begin
              state_next = S_APP_PUT;
            end else begin
              cmd.scan_start = 1'b1;
              cmd.start_kind = SS_END;
              state_next     = S_APP_SCAN;
            end
          end
          OP_CLEAR: begin
            cmd.clr_start = 1'b1;
            state_next    = S_CLR;
          end
          OP_FIND: begin
            cmd.scan_start = 1'b1;
            cmd.start_kind = SS_FIND;
            state_next     = S_SCAN;
          end
          OP_COUNT: begin
            cmd.scan_start = 1'b1;
            cmd.start_kind = SS_COUNT;
            state_next     = S_SCAN;
          end
          OP_FIT: begin
            cmd.scan_start = 1'b1;
            cmd.start_kind = SS_FIRST;
            state_next     = S_FIT1;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_SCAN, S_CLR: begin
        cmd.run = 1'b1;
        if (st.scan_done) state_next = S_DONE;
      end
      S_APP_SCAN: begin
        cmd.run = 1'b1;
        if (st.scan_done) begin
          cmd.app_begin = 1'b1;
          state_next    = S_APP_PUT;
        end
      end
      S_APP_PUT: begin
        cmd.app_put = 1'b1;
        state_next  = S_APP_END;
      end
      S_APP_END: begin
        cmd.app_mark = 1'b1;
        state_next   = S_DONE;
      end
      S_FIT1: begin
        cmd.run = 1'b1;
        if (st.scan_done) begin
          if (st.scan_hit && !st.item_whole) begin
            cmd.scan_start = 1'b1;
            cmd.start_kind = SS_FIT;
            state_next     = S_SCAN;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.res_load) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_DISPATCH))
    else $error("accepted beat did not move to dispatch");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> out_free)
    else $error("result loaded over an untaken result");

  a_done_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> (state == S_IDLE && out_valid))
    else $error("finished item did not reach the output register");

endmodule

FILE: sv/pcse_dpath.sv
// page memory, scan and clear engine, append state and result register
// depends on pcse_pkg; steered by pcse_ctrl through ctl_cmd_t
module pcse_dpath
  import pcse_pkg::*;
#(
  parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wen,
  input  logic              cfg_idx,
  input  logic [BYTE_W-1:0] cfg_wdata,
  input  logic [CMD_W-1:0]  cmd_in,
  input  logic [OFF_W-1:0]  offset,
  input  logic              whole_page,
  input  logic [LEN_W-1:0]  length,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              last_byte,
  input  ctl_cmd_t          cmd,
  output ctl_stat_t         st,
  output logic [ST_W-1:0]   status,
  output logic [IDX_W-1:0]  index,
  output logic [CNT_W-1:0]  count
);

  localparam int AW = $clog2(PAGE_BYTES);
  localparam int PW = $clog2(PAGE_BYTES + 1);
  localparam int SW = (PW > 12) ? PW : 12;
  localparam int IW = (AW > IDX_W) ? AW : IDX_W;
  localparam logic [PW-1:0] PB_P = PW'(PAGE_BYTES);
  localparam logic [SW-1:0] PB_S = SW'(PAGE_BYTES);

  typedef enum logic [1:0] {
    M_MATCH = 2'd0,
    M_COUNT = 2'd1,
    M_FIT   = 2'd2,
    M_CLEAR = 2'd3
  } mode_t;

  // configuration
  logic [BYTE_W-1:0] end_marker, empty_marker;

  // latched item
  logic [CMD_W-1:0]  item_cmd;
  logic [OFF_W-1:0]  item_off;
  logic              item_whole;
  logic [LEN_W-1:0]  item_len;
  logic [BYTE_W-1:0] item_data;
  logic              item_last;

  // page memory
  logic [BYTE_W-1:0] mem [PAGE_BYTES];
  logic [BYTE_W-1:0] rd_data;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [BYTE_W-1:0] wdata;

  // engine
  mode_t             mode, st_mode;
  logic [BYTE_W-1:0] value, st_value;
  logic [PW-1:0]     pos, st_pos, limit;
  logic              rd_valid, stop, hit;
  logic [AW-1:0]     rd_pos, hit_pos, run_start;
  logic [CNT_W-1:0]  cnt;
  logic [PW-1:0]     run_len, run_len_inc;
  logic              rd_en, clr_wr, eval, scan_done;

  // append state
  logic              app_active, app_failed;
  logic [PW-1:0]     app_cursor;
  logic [CNT_W-1:0]  app_dropped;
  logic              put_ok;

  logic              off_in_page;
  logic [PW-1:0]     off_pos, hit_pos_p;
  logic [SW-1:0]     clr_sum, clr_stop;
  logic [IW-1:0]     hit_wide;

  assign off_in_page = SW'(item_off) < PB_S;
  assign off_pos     = off_in_page ? PW'(item_off) : PB_P;
  assign hit_pos_p   = PW'(hit_pos);
  assign clr_sum     = SW'(item_off) + SW'(item_len);
  assign clr_stop    = (clr_sum > PB_S) ? PB_S : clr_sum;
  assign hit_wide    = IW'(hit_pos);
  assign put_ok      = !app_failed && (app_cursor < PB_P);
  assign run_len_inc = run_len + PW'(1);

  assign rd_en     = cmd.run && (mode != M_CLEAR) && !stop && (pos < limit);
  assign clr_wr    = cmd.run && (mode == M_CLEAR) && (pos < limit);
  assign eval      = cmd.run && (mode != M_CLEAR) && rd_valid && !stop;
  assign scan_done = stop || ((pos >= limit) && !rd_valid);

  assign st.item_cmd   = item_cmd;
  assign st.item_whole = item_whole;
  assign st.app_active = app_active;
  assign st.scan_done  = scan_done;
  assign st.scan_hit   = hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      end_marker   <= '0;
      empty_marker <= '1;
    end else if (cfg_wen) begin
      if (cfg_idx == REG_END_MARKER) end_marker <= cfg_wdata;
      else empty_marker <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      item_cmd   <= cmd_in;
      item_off   <= offset;
      item_whole <= whole_page;
      item_len   <= length;
      item_data  <= data_byte;
      item_last  <= last_byte;
    end
  end

  // one write source per cycle
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    if (cmd.wr_item && off_in_page) begin
      we    = 1'b1;
      waddr = AW'(item_off);
      wdata = item_data;
    end else if (clr_wr) begin
      we    = 1'b1;
      waddr = pos[AW-1:0];
      wdata = empty_marker;
    end else if (cmd.app_put && put_ok) begin
      we    = 1'b1;
      waddr = app_cursor[AW-1:0];
      wdata = item_data;
    end else if (cmd.app_mark && item_last && put_ok) begin
      we    = 1'b1;
      waddr = app_cursor[AW-1:0];
      wdata = end_marker;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (rd_en) rd_data <= mem[pos[AW-1:0]];
  end

  always_comb begin
    st_mode  = M_MATCH;
    st_value = empty_marker;
    st_pos   = '0;
    case (cmd.start_kind)
      SS_FIND: begin
        st_value = item_data;
        st_pos   = off_pos;
      end
      SS_COUNT: begin
        st_mode = M_COUNT;
        st_pos  = item_whole ? '0 : off_pos;
      end
      SS_END:   st_value = end_marker;
      SS_FIRST: st_value = empty_marker;
      SS_FIT: begin
        st_mode = M_FIT;
        st_pos  = (off_pos > hit_pos_p) ? off_pos : hit_pos_p;
      end
      default: st_pos = PB_P;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      stop     <= 1'b1;
      hit      <= 1'b0;
      mode     <= M_CLEAR;
      pos      <= '0;
      limit    <= '0;
    end else if (cmd.scan_start) begin
      mode     <= st_mode;
      value    <= st_value;
      pos      <= st_pos;
      limit    <= PB_P;
      rd_valid <= 1'b0;
      stop     <= 1'b0;
      hit      <= 1'b0;
      cnt      <= '0;
      run_len  <= '0;
    end else if (cmd.clr_start) begin
      mode     <= M_CLEAR;
      pos      <= off_pos;
      limit    <= PW'(clr_stop);
      rd_valid <= 1'b0;
      stop     <= 1'b0;
      hit      <= 1'b0;
    end else if (cmd.run) begin
      if (rd_en || clr_wr) pos <= pos + PW'(1);
      rd_valid <= rd_en;
      rd_pos   <= pos[AW-1:0];
      if (eval) begin
        case (mode)
          M_MATCH: begin
            if (rd_data == value) begin
              hit     <= 1'b1;
              hit_pos <= rd_pos;
              stop    <= 1'b1;
            end
          end
          M_COUNT: begin
            if (rd_data == empty_marker) begin
              if (cnt != CNT_MAX) cnt <= cnt + CNT_W'(1);
            end else if (!item_whole) begin
              stop <= 1'b1;
            end
          end
          M_FIT: begin
            if (rd_data == empty_marker) begin
              if (run_len == '0) run_start <= rd_pos;
              run_len <= run_len_inc;
              if (SW'(run_len_inc) >= SW'(item_len)) begin
                hit     <= 1'b1;
                hit_pos <= (run_len == '0) ? rd_pos : run_start;
                stop    <= 1'b1;
              end
            end else begin
              run_len <= '0;
            end
          end
          default: stop <= 1'b1;
        endcase
      end
    end
  end

  // append run bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      app_active  <= 1'b0;
      app_failed  <= 1'b0;
      app_cursor  <= '0;
      app_dropped <= '0;
    end else if (cmd.app_begin) begin
      app_active  <= 1'b1;
      app_failed  <= !hit;
      app_cursor  <= hit ? hit_pos_p : '0;
      app_dropped <= '0;
    end else if (cmd.app_put) begin
      if (put_ok) app_cursor <= app_cursor + PW'(1);
      else if (app_dropped != CNT_MAX) app_dropped <= app_dropped + CNT_W'(1);
    end else if (cmd.res_load && item_cmd == OP_APPEND && item_last) begin
      app_active  <= 1'b0;
      app_failed  <= 1'b0;
      app_cursor  <= '0;
      app_dropped <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      status <= ST_OK;
      index  <= '0;
      count  <= '0;
      case (item_cmd)
        OP_WRITE: count <= off_in_page ? '0 : CNT_W'(1);
        OP_APPEND: begin
          status <= app_failed ? ST_NO_END : ST_OK;
          count  <= item_last ? app_dropped : '0;
        end
        OP_FIND, OP_FIT: begin
          if (hit) index <= hit_wide[IDX_W-1:0];
          else status <= ST_NOT_FOUND;
        end
        OP_COUNT: count <= cnt;
        default: status <= ST_OK;
      endcase
    end
  end

  a_one_port_op: assert property (@(posedge clk) disable iff (rst)
    we |-> !rd_en)
    else $error("page write collided with a scan read");

  a_hit_stops: assert property (@(posedge clk) disable iff (rst)
    hit |-> stop)
    else $error("scan kept running after a hit");

  a_failed_cursor: assert property (@(posedge clk) disable iff (rst)
    app_failed |-> (app_cursor == '0))
    else $error("failed append run moved its cursor");

endmodule

FILE: sv/page_content_store_engine_core.sv
// page content store engine: one item at a time; accept, dispatch, work, result
// find value, count free, find fit and the first append of a run scan the page with
// one page read per cycle; clear covers its range clipped at the page end; later
// appends do not scan; page memory read port sets the pace
// rst (synchronous) clears control, append state and markers (end 0, empty 255);
// page contents are not cleared
module page_content_store_engine_core
  import pcse_pkg::*;
#(
  parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // configuration writes
  input  logic              cfg_wen,
  input  logic              cfg_idx,
  input  logic [BYTE_W-1:0] cfg_wdata,
  // command beat
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  cmd,
  input  logic [OFF_W-1:0]  offset,
  input  logic              whole_page,
  input  logic [LEN_W-1:0]  length,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              last_byte,
  // result beat
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ST_W-1:0]   status,
  output logic [IDX_W-1:0]  index,
  output logic [CNT_W-1:0]  count
);

  // controller to datapath commands and back
  ctl_cmd_t  ctl_cmd;
  ctl_stat_t ctl_stat;

  // state machine: takes a beat only when idle, sequences scans, clears and
  // append steps, then parks the result in the output register; the next
  // beat is taken while that result still waits
  pcse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (ctl_stat),
    .cmd       (ctl_cmd)
  );

  // page memory with one write and one registered read port, the byte scan
  // engine, append bookkeeping and the result register
  pcse_dpath #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .cmd_in     (cmd),
    .offset     (offset),
    .whole_page (whole_page),
    .length     (length),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .cmd        (ctl_cmd),
    .st         (ctl_stat),
    .status     (status),
    .index      (index),
    .count      (count)
  );

endmodule

FILE: verif/tb_page_content_store_engine_core.sv
`timescale 1ns / 1ps
// testbench for page_content_store_engine_core: directed table, then random phases
// checked against an in-bench page image; depends on pcse_pkg and the core only
module tb_page_content_store_engine_core;
  import pcse_pkg::*;

  localparam int PAGE       = PAGE_BYTES_DEF;
  localparam int PAW        = $clog2(PAGE);
  localparam int QUIET_MAX  = 8000;   // cycles with no beat on either side before giving up
  localparam int SETTLE_CYC = 8;
  localparam int HOLD_CYC   = 400;    // long receiver hold-off in the first random phase
  localparam int PHASE_ITEMS = 138;

  // command codes the block does not define
  localparam logic [CMD_W-1:0] OP_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] OP_SPARE7 = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0]  op;
    logic [OFF_W-1:0]  offs;
    logic              whole;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] val;
    logic              tail;
  } cmd_beat_t;

  typedef struct packed {
    logic [ST_W-1:0]  st;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] cnt;
  } result_t;

  // fixed = 1 means the typed-in result is the expectation
  typedef struct packed {
    cmd_beat_t beat;
    logic      fixed;
    result_t   res;
  } script_row_t;

  logic              clk;
  logic              rst;
  logic              cfg_wen;
  logic              cfg_idx;
  logic [BYTE_W-1:0] cfg_wdata;
  logic              in_valid;
  logic              in_ready;
  logic [CMD_W-1:0]  cmd;
  logic [OFF_W-1:0]  offset;
  logic              whole_page;
  logic [LEN_W-1:0]  length;
  logic [BYTE_W-1:0] data_byte;
  logic              last_byte;
  logic              out_valid;
  logic              out_ready;
  logic [ST_W-1:0]   status;
  logic [IDX_W-1:0]  index;
  logic [CNT_W-1:0]  count;

  page_content_store_engine_core dut (
    .clk(clk), .rst(rst),
    .cfg_wen(cfg_wen), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .offset(offset), .whole_page(whole_page), .length(length),
    .data_byte(data_byte), .last_byte(last_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .index(index), .count(count)
  );

  // 8 ns clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // page image and append bookkeeping mirrored in the bench
  logic [BYTE_W-1:0] page_img [PAGE];
  logic [BYTE_W-1:0] end_mk;
  logic [BYTE_W-1:0] empty_mk;
  bit                app_on;
  int unsigned       app_pos;
  int unsigned       app_lost;
  bit                app_fail;

  result_t pending [$];   // results still owed by the block, oldest first
  int      fails;
  int      snd_idle;      // percent of cycles the sender sits idle
  int      rcv_stall;     // percent of cycles the receiver refuses
  int      hold_req;      // hold-off length handed to the receiver process
  int      hold_left;
  int      quiet_cyc;
  result_t want;

  // directed script; rows with fixed = 0 are checked against the page image
  script_row_t script [27] = '{
    // fill the whole page with the empty marker, length equal to the page size
    '{'{OP_CLEAR, 10'd0, 1'b0, 11'd1024, 8'h00, 1'b0}, 1'b1, '{ST_OK, 10'd0, 11'd0}},
    '{'{OP_COUNT, 10'd0, 1'b1, 11'd0, 8'h00, 1'b0}, 1'b1, '{ST_OK, 10'd0, 11'd1024}},
    '{'{OP_FIND, 10'd0, 1'b0, 11'd0, 8'h00, 1'b0}, 1'b1, '{ST_NOT_FOUND, 10'd0, 11'd0}},
    // append with no end marker anywhere: whole run dropped
    '{'{OP_APPEND, 10'd0, 1'b0, 11'd0, 8'h11, 1'b0}, 1'b1, '{ST_NO_END, 10'd0, 11'd0}},
    '{'{OP_APPEND, 10'd0, 1'b0, 11'd0, 8'h22, 1'b1}, 1'b1, '{ST_NO_END, 10'd0, 11'd2}},
    '{'{OP_WRITE, 10'd1023, 1'b0, 11'd0, 8'h00, 1'b0}, 1'b1, '{ST_OK, 10'd0, 11'd0}},
    '{'{OP_FIT, 10'd0, 1'b1, 11'd0, 8'h00, 1'b0}, 1'b1, '{ST_OK, 10'd0, 11'd0}},
    '{'{OP_WRITE, 10'd0, 1'b0, 11'd0, 8'hAB, 1'b0}, 1'b1, '{ST_OK, 10'd0, 11'd0}},
    '{'{OP_FIT, 10'd0, 1'b1, 11'd0, 8'h00, 1'b0}, 1'b1, '{ST_OK, 10'd1, 11'd0}},
    // free run 1000..1022 fits 23 but not 24
    '{'{OP_FIT, 10'd1000, 1'b0, 11'd23, 8'h00, 1'b0}, 1'b1, '{ST_OK, 10'd1000, 11'd0}},
    '{'{OP_FIT, 10'd1000, 1'b0, 11'd24, 8'h00, 1'b0}, 1'b1, '{ST_NOT_FOUND, 10'd0, 11'd0}},
    // zero length fit, offset below the first empty byte
    '{'{OP_FIT, 10'd0, 1'b0, 11'd0, 8'h00, 1'b0}, 1'b0, '{ST_OK, 10'd0, 11'd0}},
    '{'{OP_FIND, 10'd1023, 1'b0, 11'd0, 8'h00, 1'b0}, 1'b1, '{ST_OK, 10'd1023, 11'd0}},
    '{'{OP_COUNT, 10'd1, 1'b0, 11'd0, 8'h00, 1'b0}, 1'b1, '{ST_OK, 10'd0, 11'd1022}},
    '{'{OP_COUNT, 10'd1023, 1'b0, 11'd0, 8'h00, 1'b0}, 1'b1, '{ST_OK, 10'd0, 11'd0}},
    // append at the last byte: overflow, no end marker written
    '{'{OP_APPEND, 10'd0, 1'b0, 11'd0, 8'h31, 1'b0}, 1'b1, '{ST_OK, 10'd0, 11'd0}},
    '{'{OP_APPEND, 10'd0, 1'b0, 11'd0, 8'h32, 1'b0}, 1'b1, '{ST_OK, 10'd0, 11'd0}},
    '{'{OP_APPEND, 10'd0, 1'b0, 11'd0, 8'h33, 1'b1}, 1'b1, '{ST_OK, 10'd0, 11'd2}},
    // clear past the page end gets clipped
    '{'{OP_CLEAR, 10'd1020, 1'b0, 11'd1024, 8'h00, 1'b0}, 1'b1, '{ST_OK, 10'd0, 11'd0}},
    '{'{OP_COUNT, 10'd0, 1'b1, 11'd0, 8'h00, 1'b0}, 1'b0, '{ST_OK, 10'd0, 11'd0}},
    // undefined commands, one with high field values and one with every field zero
    '{'{OP_SPARE6, 10'd1023, 1'b1, 11'd1024, 8'hFF, 1'b1}, 1'b1, '{ST_OK, 10'd0, 11'd0}},
    '{'{OP_SPARE7, 10'd0, 1'b0, 11'd0, 8'h00, 1'b0}, 1'b1, '{ST_OK, 10'd0, 11'd0}},
    // append run with a search in the middle of it
    '{'{OP_WRITE, 10'd5, 1'b0, 11'd0, 8'h00, 1'b0}, 1'b1, '{ST_OK, 10'd0, 11'd0}},
    '{'{OP_APPEND, 10'd0, 1'b0, 11'd0, 8'h44, 1'b0}, 1'b0, '{ST_OK, 10'd0, 11'd0}},
    '{'{OP_FIND, 10'd0, 1'b0, 11'd0, 8'h44, 1'b0}, 1'b0, '{ST_OK, 10'd0, 11'd0}},
    '{'{OP_APPEND, 10'd0, 1'b0, 11'd0, 8'h45, 1'b1}, 1'b0, '{ST_OK, 10'd0, 11'd0}},
    '{'{OP_FIND, 10'd0, 1'b0, 11'd0, 8'h00, 1'b0}, 1'b0, '{ST_OK, 10'd0, 11'd0}}
  };

  // apply one command to the page image and return the result it should give
  function automatic result_t serve_command(input cmd_beat_t b);
    result_t     r;
    int unsigned p;
    int unsigned stop;
    int unsigned first;
    int unsigned run_at;
    int unsigned run_n;
    int unsigned tally;
    bit          hit;
    r = '{ST_OK, '0, '0};
    hit = 1'b0;
    case (b.op)
      OP_WRITE: begin
        page_img[b.offs] = b.val;   // a 10-bit offset always lands inside the page
      end
      OP_APPEND: begin
        // first beat of a run looks for the end marker from the page start
        if (!app_on) begin
          app_on = 1'b1;
          app_lost = 0;
          app_fail = 1'b1;
          app_pos = 0;
          for (p = 0; p < PAGE && app_fail; p++) begin
            if (page_img[p[PAW-1:0]] == end_mk) begin
              app_pos = p;
              app_fail = 1'b0;
            end
          end
        end
        if (!app_fail && app_pos < PAGE) begin
          page_img[app_pos[PAW-1:0]] = b.val;
          app_pos++;
        end else if (app_lost < CNT_MAX) begin
          app_lost++;
        end
        r.st = app_fail ? ST_NO_END : ST_OK;
        if (b.tail) begin
          if (!app_fail && app_pos < PAGE) page_img[app_pos[PAW-1:0]] = end_mk;
          r.cnt = app_lost[CNT_W-1:0];
          app_on = 1'b0;
          app_pos = 0;
          app_lost = 0;
          app_fail = 1'b0;
        end
      end
      OP_CLEAR: begin
        stop = b.offs + b.len;
        if (stop > PAGE) stop = PAGE;
        for (p = b.offs; p < stop; p++) page_img[p[PAW-1:0]] = empty_mk;
      end
      OP_FIND: begin
        for (p = b.offs; p < PAGE && !hit; p++) begin
          if (page_img[p[PAW-1:0]] == b.val) begin
            hit = 1'b1;
            r.idx = p[IDX_W-1:0];
          end
        end
        if (!hit) r.st = ST_NOT_FOUND;
      end
      OP_COUNT: begin
        tally = 0;
        for (p = b.whole ? 0 : b.offs; p < PAGE && !hit; p++) begin
          if (page_img[p[PAW-1:0]] == empty_mk) tally++;
          else if (!b.whole) hit = 1'b1;   // run ends at first used byte
        end
        r.cnt = tally[CNT_W-1:0];
      end
      OP_FIT: begin
        first = PAGE;
        for (p = 0; p < PAGE && first == PAGE; p++) begin
          if (page_img[p[PAW-1:0]] == empty_mk) first = p;
        end
        if (first >= PAGE) begin
          r.st = ST_NOT_FOUND;
        end else if (b.whole) begin
          r.idx = first[IDX_W-1:0];
        end else begin
          run_at = 0;
          run_n = 0;
          for (p = (b.offs > first) ? b.offs : first; p < PAGE && !hit; p++) begin
            if (page_img[p[PAW-1:0]] == empty_mk) begin
              if (run_n == 0) run_at = p;
              run_n++;
              if (run_n >= b.len) begin
                hit = 1'b1;
                r.idx = run_at[IDX_W-1:0];
              end
            end else begin
              run_n = 0;
            end
          end
          if (!hit) r.st = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // random fields, op set to a write; the caller then shapes the ones that matter
  function automatic cmd_beat_t noise_beat();
    cmd_beat_t b;
    b.op    = OP_WRITE;
    b.offs  = OFF_W'($urandom_range(PAGE - 1, 0));
    b.whole = 1'($urandom_range(1, 0));
    b.len   = LEN_W'($urandom_range(1024, 0));
    b.val   = BYTE_W'($urandom_range(255, 0));
    b.tail  = 1'($urandom_range(1, 0));
    return b;
  endfunction

  // offer one command beat, wait for the handshake, then record what it should give
  task automatic send_beat(input cmd_beat_t b, input bit fixed, input result_t fixed_res);
    result_t guess;
    while ($urandom_range(99, 0) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= b.op;
    offset     <= b.offs;
    whole_page <= b.whole;
    length     <= b.len;
    data_byte  <= b.val;
    last_byte  <= b.tail;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    guess = serve_command(b);
    pending.push_back(fixed ? fixed_res : guess);
  endtask

  // wait for every owed result, then let the bench settle
  task automatic settle();
    while (pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // both marker registers, one write per cycle
  task automatic set_markers(input logic [BYTE_W-1:0] e_val, input logic [BYTE_W-1:0] f_val);
    cfg_wen   <= 1'b1;
    cfg_idx   <= REG_END_MARKER;
    cfg_wdata <= e_val;
    @(posedge clk);
    cfg_idx   <= REG_EMPTY_MARKER;
    cfg_wdata <= f_val;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    end_mk   = e_val;
    empty_mk = f_val;
  endtask

  // mostly append runs and scans over a page that keeps getting rewritten
  task automatic random_phase(input int n_items);
    cmd_beat_t b;
    int        left;
    int        run_left;
    int        pick;
    int        sel;
    left = n_items;
    run_left = 0;
    while (left > 0 || run_left > 0) begin
      b = noise_beat();
      pick = $urandom_range(99, 0);
      if (run_left > 0 && (pick < 70 || left <= 0)) begin
        // next beat of the running append
        b.op = OP_APPEND;
        run_left--;
        b.tail = (run_left == 0);
        if (!b.tail && $urandom_range(99, 0) < 4) begin
          b.tail = 1'b1;   // cut the run short
          run_left = 0;
        end
      end else if (run_left == 0 && pick < 20) begin
        b.op = OP_APPEND;
        run_left = ($urandom_range(9, 0) == 0) ? $urandom_range(60, 30) : $urandom_range(12, 1);
        run_left--;
        b.tail = (run_left == 0);
      end else begin
        sel = $urandom_range(99, 0);
        if (sel < 28) begin
          b.op = OP_WRITE;
          if ($urandom_range(4, 0) == 0) b.offs = OFF_W'($urandom_range(PAGE - 1, PAGE - 40));
          case ($urandom_range(9, 0))
            0, 1, 2: b.val = end_mk;
            3, 4:    b.val = empty_mk;
            default: ;
          endcase
        end else if (sel < 46) begin
          b.op = OP_CLEAR;
          case ($urandom_range(19, 0))
            0:          b.len = LEN_W'($urandom_range(1024, 512));
            1, 2, 3:    b.len = LEN_W'($urandom_range(256, 33));
            default:    b.len = LEN_W'($urandom_range(32, 0));
          endcase
        end else if (sel < 62) begin
          b.op = OP_FIND;
          case ($urandom_range(9, 0))
            0, 1, 2, 3: b.val = end_mk;
            4, 5:       b.val = empty_mk;
            default:    ;
          endcase
        end else if (sel < 78) begin
          b.op = OP_COUNT;
        end else if (sel < 96) begin
          b.op = OP_FIT;
          b.whole = ($urandom_range(9, 0) < 3);
          case ($urandom_range(19, 0))
            0:             b.len = LEN_W'($urandom_range(1024, 65));
            1, 2, 3, 4, 5: b.len = LEN_W'($urandom_range(64, 9));
            default:       b.len = LEN_W'($urandom_range(8, 0));
          endcase
        end else begin
          b.op = $urandom_range(1, 0) ? OP_SPARE6 : OP_SPARE7;
        end
      end
      send_beat(b, 1'b0, '0);
      if (b.op != OP_SPARE6 && b.op != OP_SPARE7) left--;
    end
  endtask

  task automatic compare_field(input string what, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, exp_v, got_v);
      fails++;
    end
  endtask

  // result side: check each accepted beat, then pick ready for the next cycle
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual %0d/%0d/%0d",
                 $time, status, index, count);
        fails++;
      end else begin
        want = pending.pop_front();
        compare_field("status", int'(want.st), int'(status));
        compare_field("index", int'(want.idx), int'(index));
        compare_field("count", int'(want.cnt), int'(count));
      end
    end
    // a hold-off request wins over random stalls until it runs out
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99, 0) >= rcv_stall);
    end
  end

  // watchdog: too long without a beat on either side means a hang
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cyc = 0;
    end else begin
      quiet_cyc++;
    end
    if (quiet_cyc >= QUIET_MAX) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    // every input known from time zero, reset held at the start
    rst        = 1'b1;
    cfg_wen    = 1'b0;
    cfg_idx    = REG_END_MARKER;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    cmd        = OP_WRITE;
    offset     = '0;
    whole_page = 1'b0;
    length     = '0;
    data_byte  = '0;
    last_byte  = 1'b0;
    out_ready  = 1'b0;
    fails      = 0;
    snd_idle   = 0;
    rcv_stall  = 0;
    hold_req   = 0;
    hold_left  = 0;
    quiet_cyc  = 0;
    for (int p = 0; p < PAGE; p++) page_img[p[PAW-1:0]] = '0;
    end_mk   = 8'd0;
    empty_mk = 8'd255;
    app_on   = 1'b0;
    app_pos  = 0;
    app_lost = 0;
    app_fail = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed script at reset marker values, no idling
    for (int r = 0; r < 27; r++) begin
      send_beat(script[r[4:0]].beat, script[r[4:0]].fixed, script[r[4:0]].res);
    end

    // random phases, each with its own markers and idling mix
    for (int ph = 0; ph < 4; ph++) begin
      in_valid <= 1'b0;
      settle();
      case (ph)
        0: begin
          set_markers(8'd0, 8'd255);
          snd_idle = 0;
          rcv_stall = 0;
          hold_req = HOLD_CYC;   // receiver backs off while commands keep coming
        end
        1: begin
          set_markers(8'd255, 8'd0);
          snd_idle = 62;
          rcv_stall = 0;
        end
        2: begin
          set_markers(8'h3C, 8'hC3);
          snd_idle = 0;
          rcv_stall = 62;
        end
        default: begin
          // both markers equal: every empty byte also reads as an end marker
          set_markers(8'h80, 8'h80);
          snd_idle = 36;
          rcv_stall = 36;
        end
      endcase
      random_phase(PHASE_ITEMS);
    end

    in_valid <= 1'b0;
    settle();
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/pcse_pkg.sv
sv/pcse_ctrl.sv
sv/pcse_dpath.sv
sv/page_content_store_engine_core.sv
verif/tb_page_content_store_engine_core.sv
